// File: rtl/rhvp_pkg.sv
// shared types and constants for the rpc header varint parser
package rhvp_pkg;

  localparam logic [6:0] VarintData   = 7'h7f;
  localparam int unsigned VarintMore  = 7;
  localparam logic [7:0] NoExtraReset = 8'hfe;
  localparam logic [6:0] ShiftStep    = 7'd7;
  localparam logic [4:0] ByteCountMax = 5'd31;

  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;
  localparam logic [0:0] RegNoExtraService = 1'b0;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_METHOD,
    PH_REQLO,
    PH_REQHI,
    PH_EXTRA,
    PH_PAYLD
  } phase_e;

  typedef struct packed {
    logic        status;
    logic [7:0]  service;
    logic [31:0] method;
    logic [15:0] request_id;
    logic        extra_present;
    logic [63:0] extra_value;
    logic [31:0] payload_length;
    logic [4:0]  header_length;
    logic [32:0] total_length;
  } result_t;

endpackage

// File: rtl/rhvp_apb_regs.sv
// apb configuration register holding the no-extra service code
module rhvp_apb_regs import rhvp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready,
  output logic [7:0]          no_extra_service_o
);

  logic [7:0] no_extra_q;
  logic [7:0] no_extra_d;
  logic       sel_reg;

  assign sel_reg = (paddr[CfgAddrW-1:2] == RegNoExtraService);

  always_comb begin
    no_extra_d = no_extra_q;
    if (psel && penable && pwrite && sel_reg) begin
      no_extra_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_extra_q <= NoExtraReset;
    end else begin
      no_extra_q <= no_extra_d;
    end
  end

  assign prdata             = sel_reg ? {{(CfgDataW-8){1'b0}}, no_extra_q} : '0;
  assign pready             = 1'b1;
  assign no_extra_service_o = no_extra_q;

endmodule

// File: rtl/rhvp_core.sv
// header parse state and per-byte field accumulation
module rhvp_core import rhvp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] data_byte_i,
  input  logic       first_byte_i,
  input  logic       last_byte_i,
  input  logic [7:0] no_extra_service_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  service_q, service_d;
  logic [31:0] method_q, method_d;
  logic [15:0] request_q, request_d;
  logic [63:0] extra_q, extra_d;
  logic [31:0] payload_q, payload_d;
  logic [6:0]  shift_q, shift_d;
  logic [4:0]  count_q, count_d;

  logic        more;
  logic [63:0] grp_shifted;
  logic        fits32;
  logic        fits64;
  logic [6:0]  shift_inc;
  logic        emit_ok;
  logic        emit_trunc;
  logic        has_extra;

  assign more        = data_byte_i[VarintMore];
  assign grp_shifted = {57'd0, data_byte_i[6:0] & VarintData} << shift_q[5:0];
  assign fits64      = !shift_q[6];
  assign fits32      = (shift_q[6:5] == 2'b00);
  assign shift_inc   = fits64 ? (shift_q + ShiftStep) : shift_q;
  assign has_extra   = (service_q != no_extra_service_i);

  always_comb begin
    phase_d    = phase_q;
    service_d  = service_q;
    method_d   = method_q;
    request_d  = request_q;
    extra_d    = extra_q;
    payload_d  = payload_q;
    shift_d    = shift_q;
    count_d    = count_q;
    emit_ok    = 1'b0;
    emit_trunc = 1'b0;
    if (step_i) begin
      if (first_byte_i) begin
        service_d  = data_byte_i;
        method_d   = '0;
        request_d  = '0;
        extra_d    = '0;
        payload_d  = '0;
        shift_d    = '0;
        count_d    = 5'd1;
        phase_d    = last_byte_i ? PH_IDLE : PH_METHOD;
        emit_trunc = last_byte_i;
      end else if (phase_q != PH_IDLE) begin
        if (count_q != ByteCountMax) begin
          count_d = count_q + 5'd1;
        end
        unique case (phase_q)
          PH_METHOD: begin
            if (fits32) begin
              method_d = method_q | grp_shifted[31:0];
            end
            shift_d = shift_inc;
            if (!more) begin
              phase_d = PH_REQLO;
              shift_d = '0;
            end
          end
          PH_REQLO: begin
            request_d = {8'd0, data_byte_i};
            phase_d   = PH_REQHI;
          end
          PH_REQHI: begin
            request_d = {data_byte_i, request_q[7:0]};
            shift_d   = '0;
            phase_d   = has_extra ? PH_EXTRA : PH_PAYLD;
          end
          PH_EXTRA: begin
            if (fits64) begin
              extra_d = extra_q | grp_shifted;
            end
            shift_d = shift_inc;
            if (!more) begin
              phase_d = PH_PAYLD;
              shift_d = '0;
            end
          end
          PH_PAYLD: begin
            if (fits32) begin
              payload_d = payload_q | grp_shifted[31:0];
            end
            shift_d = shift_inc;
            if (!more) begin
              emit_ok = 1'b1;
              phase_d = PH_IDLE;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
        if (!emit_ok && last_byte_i) begin
          emit_trunc = 1'b1;
          phase_d    = PH_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      service_q <= '0;
      method_q  <= '0;
      request_q <= '0;
      extra_q   <= '0;
      payload_q <= '0;
      shift_q   <= '0;
      count_q   <= '0;
    end else begin
      phase_q   <= phase_d;
      service_q <= service_d;
      method_q  <= method_d;
      request_q <= request_d;
      extra_q   <= extra_d;
      payload_q <= payload_d;
      shift_q   <= shift_d;
      count_q   <= count_d;
    end
  end

  always_comb begin
    res_o = '0;
    if (emit_trunc) begin
      res_o.status = 1'b1;
    end else begin
      res_o.service        = service_q;
      res_o.method         = method_q;
      res_o.request_id     = request_q;
      res_o.extra_present  = has_extra;
      res_o.extra_value    = has_extra ? extra_q : '0;
      res_o.payload_length = payload_d;
      res_o.header_length  = count_d;
      res_o.total_length   = {1'b0, payload_d} + {28'd0, count_d};
    end
  end

  assign res_valid_o = emit_ok || emit_trunc;

endmodule

// File: rtl/rpc_header_varint_parser.sv
// rpc header varint parser top level: input register, parse stage, result register
//
//   channel | handshake                | payload
//   --------+--------------------------+-----------------------------------------
//   in      | in_valid_i / in_ready_o  | data_byte_i, first_byte_i, last_byte_i
//   out     | out_valid_o / out_ready_i| status_o .. total_length_o
//   cfg     | apb psel/penable/pready  | no_extra_service at byte address 0
//
// one byte per cycle while the result register is not stalled; the result of a byte, if any,
// is formed from the input register and captured in the result register as the byte leaves it
// the parse state feeds back on itself once per cycle, which sets the rate
// reset returns the parser to idle and the service code register to 0xfe
// a stalled result holds the parse stage; the input register then fills and
// in_ready_o falls
module rpc_header_varint_parser import rhvp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                first_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                status_o,
  output logic [7:0]          service_o,
  output logic [31:0]         method_o,
  output logic [15:0]         request_id_o,
  output logic                extra_present_o,
  output logic [63:0]         extra_value_o,
  output logic [31:0]         payload_length_o,
  output logic [4:0]          header_length_o,
  output logic [32:0]         total_length_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [CfgDataW-1:0] pwdata,
  output logic [CfgDataW-1:0] prdata,
  output logic                pready
);

  logic       item_valid_q, item_valid_d;
  logic [7:0] item_byte_q;
  logic       item_first_q;
  logic       item_last_q;
  logic       out_valid_q, out_valid_d;
  result_t    out_q;
  logic       advance;
  logic       step;
  logic       res_valid;
  result_t    res;
  logic [7:0] no_extra_service;

  rhvp_apb_regs u_regs (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .no_extra_service_o (no_extra_service)
  );

  assign advance    = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && advance;
  assign in_ready_o = !item_valid_q || advance;

  rhvp_core u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .data_byte_i        (item_byte_q),
    .first_byte_i       (item_first_q),
    .last_byte_i        (item_last_q),
    .no_extra_service_i (no_extra_service),
    .res_valid_o        (res_valid),
    .res_o              (res)
  );

  always_comb begin
    item_valid_d = item_valid_q;
    if (in_ready_o) begin
      item_valid_d = in_valid_i;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = step && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      item_valid_q <= item_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_byte_q  <= data_byte_i;
      item_first_q <= first_byte_i;
      item_last_q  <= last_byte_i;
    end
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_q.status;
  assign service_o        = out_q.service;
  assign method_o         = out_q.method;
  assign request_id_o     = out_q.request_id;
  assign extra_present_o  = out_q.extra_present;
  assign extra_value_o    = out_q.extra_value;
  assign payload_length_o = out_q.payload_length;
  assign header_length_o  = out_q.header_length;
  assign total_length_o   = out_q.total_length;

endmodule

// File: test/tb_rpc_header_varint_parser.sv
// testbench for the rpc header varint parser: random packet byte streams checked against a parallel header decoder
module tb_rpc_header_varint_parser;
  import rhvp_pkg::*;

  localparam int unsigned StallLimit    = 2000;
  localparam int unsigned HoldOffCycles = 400;
  localparam int unsigned HoldOffAfter  = 60;
  localparam int unsigned DrainCycles   = 8;
  localparam int unsigned PhaseBytes    = 430;

  typedef struct packed {
    logic [7:0] data;
    logic       is_first;
    logic       is_last;
  } pkt_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  logic [7:0]          data_byte_i = '0;
  logic                first_byte_i = 1'b0;
  logic                last_byte_i = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic                status_o;
  logic [7:0]          service_o;
  logic [31:0]         method_o;
  logic [15:0]         request_id_o;
  logic                extra_present_o;
  logic [63:0]         extra_value_o;
  logic [31:0]         payload_length_o;
  logic [4:0]          header_length_o;
  logic [32:0]         total_length_o;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  rpc_header_varint_parser dut (.*);

  always #5 clk_i = ~clk_i;

  // decoder state
  phase_e      ph = PH_IDLE;
  logic [7:0]  svc = '0;
  logic [31:0] meth = '0;
  logic [15:0] reqid = '0;
  logic [63:0] extra = '0;
  logic [31:0] payld = '0;
  logic [6:0]  shift = '0;
  logic [4:0]  bcount = '0;
  logic [7:0]  cfg_code = NoExtraReset;

  logic [7:0]  code_now = NoExtraReset;
  pkt_byte_t   byte_queue[$];
  result_t     due_results[$];
  logic [7:0]  hdr_bytes[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int unsigned headers_seen = 0;
  int unsigned truncs_seen = 0;
  int unsigned capped_seen = 0;
  int unsigned results_seen = 0;
  int unsigned settings_done = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int          send_gap = 0;
  int          ready_gap = 0;
  int          hold_left = 0;
  int          tx_calm = 0;
  int          rx_calm = 0;

  function automatic logic [63:0] varint_merge(input logic [63:0] acc, input logic [7:0] b,
                                               input int unsigned width);
    logic [63:0] grp;
    grp = {56'h0, b & {1'b0, VarintData}};
    if (shift < width && shift < 64) acc |= grp << shift;
    if (shift < 64) shift += ShiftStep;
    return acc;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic is_first,
                                    input logic is_last, output result_t r);
    logic more;
    more = b[VarintMore];
    r = '0;
    if (is_first) begin
      svc = b;
      meth = '0;
      reqid = '0;
      extra = '0;
      payld = '0;
      shift = '0;
      bcount = 5'd1;
      ph = PH_METHOD;
      if (is_last) begin
        r.status = 1'b1;
        ph = PH_IDLE;
        return 1'b1;
      end
      return 1'b0;
    end
    if (ph == PH_IDLE) return 1'b0;
    if (bcount < ByteCountMax) bcount++;
    case (ph)
      PH_METHOD: begin
        meth = 32'(varint_merge({32'h0, meth}, b, 32));
        if (!more) begin
          ph = PH_REQLO;
          shift = '0;
        end
      end
      PH_REQLO: begin
        reqid = {8'h00, b};
        ph = PH_REQHI;
      end
      PH_REQHI: begin
        reqid[15:8] = b;
        shift = '0;
        ph = (svc == cfg_code) ? PH_PAYLD : PH_EXTRA;
      end
      PH_EXTRA: begin
        extra = varint_merge(extra, b, 64);
        if (!more) begin
          ph = PH_PAYLD;
          shift = '0;
        end
      end
      default: begin
        payld = 32'(varint_merge({32'h0, payld}, b, 32));
        if (!more) begin
          r.status = 1'b0;
          r.service = svc;
          r.method = meth;
          r.request_id = reqid;
          r.extra_present = (svc != cfg_code);
          r.extra_value = r.extra_present ? extra : 64'h0;
          r.payload_length = payld;
          r.header_length = bcount;
          r.total_length = 33'(bcount) + 33'(payld);
          ph = PH_IDLE;
          return 1'b1;
        end
      end
    endcase
    if (is_last) begin
      r.status = 1'b1;
      ph = PH_IDLE;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(30, 150);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin : drv
    result_t hdr;
    pkt_byte_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        bytes_taken++;
        if (parse_byte(data_byte_i, first_byte_i, last_byte_i, hdr)) due_results.push_back(hdr);
        send_gap = pick_gap(tx_calm);
      end
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (byte_queue.size() != 0) begin
          nxt = byte_queue.pop_front();
          data_byte_i <= nxt.data;
          first_byte_i <= nxt.is_first;
          last_byte_i <= nxt.is_last;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : mon
    result_t got;
    result_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{status_o, service_o, method_o, request_id_o, extra_present_o, extra_value_o,
                payload_length_o, header_length_o, total_length_o};
        if (due_results.size() == 0) begin
          $error("result with nothing expected: status %0d service 0x%0h", status_o, service_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("service", 64'(want.service), 64'(got.service));
          check_field("method", 64'(want.method), 64'(got.method));
          check_field("request_id", 64'(want.request_id), 64'(got.request_id));
          check_field("extra_present", 64'(want.extra_present), 64'(got.extra_present));
          check_field("extra_value", want.extra_value, got.extra_value);
          check_field("payload_length", 64'(want.payload_length), 64'(got.payload_length));
          check_field("header_length", 64'(want.header_length), 64'(got.header_length));
          check_field("total_length", 64'(want.total_length), 64'(got.total_length));
          if (want.status) truncs_seen++;
          else headers_seen++;
          if (!want.status && want.header_length == ByteCountMax) capped_seen++;
        end
        results_seen++;
        if (results_seen == HoldOffAfter) hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        out_ready_i <= 1'b0;
      end else begin
        ready_gap = ($urandom_range(0, 7) == 0) ? pick_gap(rx_calm) : 0;
        out_ready_i <= (ready_gap == 0);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void push_item(input logic [7:0] b, input logic is_first,
                                    input logic is_last);
    byte_queue.push_back('{b, is_first, is_last});
    bytes_queued++;
  endfunction

  function automatic logic [63:0] pick_value(input bit wide);
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = wide ? '1 : 64'hffff_ffff;
      default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    if (!wide && $urandom_range(0, 4) != 0) v &= 64'hffff_ffff;
    return v;
  endfunction

  function automatic int pick_pad();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return 0;
    if (r < 98) return $urandom_range(1, 3);
    return $urandom_range(10, 25);
  endfunction

  // overlong tails carry random groups, most of them beyond the field width
  function automatic void put_varint(input logic [63:0] v, input int pad);
    logic [63:0] rest;
    logic [6:0]  grp;
    rest = v;
    do begin
      grp = rest[6:0];
      rest = rest >> 7;
      hdr_bytes.push_back({(rest != 0 || pad != 0), grp});
    end while (rest != 0);
    for (int i = 0; i < pad; i++) hdr_bytes.push_back({(i != pad - 1), 7'($urandom)});
  endfunction

  task automatic gen_header();
    logic [7:0] code;
    int kind;
    int cut;
    bit end_last;
    hdr_bytes.delete();
    code = ($urandom_range(0, 2) == 0) ? code_now : 8'($urandom);
    hdr_bytes.push_back(code);
    put_varint(pick_value(1'b0), pick_pad());
    hdr_bytes.push_back(8'($urandom));
    hdr_bytes.push_back(8'($urandom));
    if (code != code_now) put_varint(pick_value(1'b1), pick_pad());
    put_varint(pick_value(1'b0), pick_pad());
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      cut = hdr_bytes.size();
      end_last = ($urandom_range(0, 9) < 3);
    end else begin
      cut = $urandom_range(1, hdr_bytes.size() - 1);
      end_last = (kind < 85);
    end
    for (int i = 0; i < cut; i++) push_item(hdr_bytes[i], i == 0, end_last && i == cut - 1);
  endtask

  task automatic run_phase(input int unsigned n);
    int unsigned stop;
    stop = bytes_queued + n;
    while (bytes_queued < stop) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          push_item(8'($urandom), $urandom_range(0, 9) == 0, 1'($urandom_range(0, 1)));
        end
      end
      gen_header();
    end
    // leave the parser idle before the next register write
    push_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_idle();
    while (byte_queue.size() != 0 || in_valid_i || due_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_code(input logic [7:0] code);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CfgAddrW'(RegNoExtraService) << 2;
    pwdata <= CfgDataW'(code);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cfg_code = code;
    code_now = code;
    settings_done++;
  endtask

  initial begin
    logic [7:0] codes[4];
    codes[0] = 8'h00;
    codes[1] = 8'hff;
    codes[2] = 8'($urandom_range(1, 253));
    codes[3] = NoExtraReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // stray bytes before any buffer
    push_item(8'h55, 1'b0, 1'b0);
    push_item(8'h81, 1'b0, 1'b1);
    // buffer of a single byte
    push_item(8'hff, 1'b1, 1'b1);
    // header without the optional field, complete on the buffer's last byte
    push_item(NoExtraReset, 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    // restart in the middle of the method varint
    push_item(NoExtraReset, 1'b1, 1'b0);
    push_item(8'h81, 1'b0, 1'b0);
    push_item(8'h07, 1'b1, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(8'h34, 1'b0, 1'b0);
    push_item(8'h12, 1'b0, 1'b0);
    push_item(8'h05, 1'b0, 1'b0);
    push_item(8'h02, 1'b0, 1'b0);
    // ignored once the header is done
    push_item(8'haa, 1'b0, 1'b0);
    // buffer cut inside the method varint
    push_item(8'h09, 1'b1, 1'b0);
    push_item(8'h85, 1'b0, 1'b1);
    wait_idle();

    foreach (codes[i]) begin
      write_code(codes[i]);
      run_phase(PhaseBytes);
      wait_idle();
    end

    $display("%0d bytes sent, %0d headers parsed (%0d at the length cap), %0d truncations",
             bytes_taken, headers_seen, capped_seen, truncs_seen);
    $display("%0d no-extra service codes written, one receiver hold-off of %0d cycles",
             settings_done, HoldOffCycles);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
